### rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg - shared types and constants of the PLL frequency programmer
// Field widths, arithmetic constants, register map and the write sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

    // field widths
    localparam int unsigned FREQ_W = 22;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 24;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned DIV_W  = 6;
    localparam int unsigned QUO_W  = 8;
    localparam int unsigned INT_W  = 6;
    localparam int unsigned FRAC_W = 24;
    localparam int unsigned REM_W  = 16;
    localparam int unsigned IDX_W  = 4;

    localparam int unsigned NUM_WRITES = 13;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WRITES - 1);

    // request range and divider selection
    localparam logic [FREQ_W-1:0] FREQ_MIN_KHZ  = 22'd25000;
    localparam logic [FREQ_W-1:0] FREQ_MAX_KHZ  = 22'd3000000;
    localparam logic [FREQ_W-1:0] FREQ_DIV1_KHZ = 22'd1500000;
    localparam logic [DIV_W-1:0]  DIV_ONE       = 6'd1;
    localparam logic [DIV_W-1:0]  DIV_MIN       = 6'd2;
    localparam logic [DIV_W-1:0]  DIV_MAX       = 6'd62;
    localparam logic [QUO_W-1:0]  QUO_LOW       = 8'd3;

    // divider control word
    localparam logic [WORD_W-1:0] DIVWORD_BASE   = 16'h6010;
    localparam logic [WORD_W-1:0] DIVWORD_LOWDIV = 16'h8000;
    localparam int unsigned       DIVWORD_SHIFT  = 7;

    // phase detector rate in kHz (50 MHz)
    localparam logic [REM_W-1:0] PFD_KHZ = 16'd50000;

    // exact reciprocal constants: floor(x/D) = (x*M) >> S over the used range
    localparam logic [22:0] INT_RECIP = 23'd5497559;   // 1/50000, S = 38
    localparam int unsigned INT_SHIFT = 38;
    localparam logic [16:0] R25_RECIP = 17'd83887;     // 1/25, S = 21
    localparam int unsigned R25_SHIFT = 21;
    localparam logic [16:0] R250_RECIP = 17'd67109;    // 1/250, S = 24
    localparam int unsigned R250_SHIFT = 24;
    localparam logic [17:0] R7_RECIP  = 18'd214749;    // 1/10000, S = 31
    localparam int unsigned R7_SHIFT  = 31;
    localparam logic [8:0]  FRAC_LINEAR = 9'd335;      // 300 + 30 + 5

    // PLL register map
    localparam logic [ADDR_W-1:0] REG_RESET       = 5'h00;
    localparam logic [ADDR_W-1:0] REG_REF_DIV     = 5'h01;
    localparam logic [ADDR_W-1:0] REG_POWER       = 5'h02;
    localparam logic [ADDR_W-1:0] REG_INT         = 5'h03;
    localparam logic [ADDR_W-1:0] REG_FRAC        = 5'h04;
    localparam logic [ADDR_W-1:0] REG_VCO_SPI     = 5'h05;
    localparam logic [ADDR_W-1:0] REG_SD_CFG      = 5'h06;
    localparam logic [ADDR_W-1:0] REG_LOCK_DET    = 5'h07;
    localparam logic [ADDR_W-1:0] REG_CHARGE_PUMP = 5'h09;
    localparam logic [ADDR_W-1:0] REG_VCO_CAL     = 5'h0A;
    localparam logic [ADDR_W-1:0] REG_GPO         = 5'h0F;

    // fixed register contents
    localparam logic [DATA_W-1:0] DATA_RESET       = 24'h000020;
    localparam logic [DATA_W-1:0] DATA_REF_DIV     = 24'h000002;
    localparam logic [DATA_W-1:0] DATA_POWER       = 24'h000002;
    localparam logic [DATA_W-1:0] DATA_VCO_TUNE    = 24'h002898;
    localparam logic [DATA_W-1:0] DATA_VCO_CLEAR   = 24'h000000;
    localparam logic [DATA_W-1:0] DATA_SD_CFG      = 24'h200B4A;
    localparam logic [DATA_W-1:0] DATA_LOCK_DET    = 24'h000CCD;
    localparam logic [DATA_W-1:0] DATA_CHARGE_PUMP = 24'h543FFF;
    localparam logic [DATA_W-1:0] DATA_VCO_CAL     = 24'h002046;
    localparam logic [DATA_W-1:0] DATA_GPO         = 24'h000081;

    // one computed programming job
    typedef struct packed {
        logic [WORD_W-1:0] div_word;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV,
        FS_MUL,
        FS_INT,
        FS_REM,
        FS_FRAC,
        FS_SUM,
        FS_PUSH
    } t_front_state;

    function automatic logic [ADDR_W-1:0] wr_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        case (idx)
            4'd0:    a = REG_RESET;
            4'd1:    a = REG_REF_DIV;
            4'd2:    a = REG_POWER;
            4'd3:    a = REG_VCO_SPI;
            4'd4:    a = REG_VCO_SPI;
            4'd5:    a = REG_VCO_SPI;
            4'd6:    a = REG_SD_CFG;
            4'd7:    a = REG_LOCK_DET;
            4'd8:    a = REG_CHARGE_PUMP;
            4'd9:    a = REG_VCO_CAL;
            4'd10:   a = REG_GPO;
            4'd11:   a = REG_INT;
            4'd12:   a = REG_FRAC;
            default: a = REG_RESET;
        endcase
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] wr_data(input logic [IDX_W-1:0] idx,
                                                  input t_job job);
        logic [DATA_W-1:0] d;
        case (idx)
            4'd0:    d = DATA_RESET;
            4'd1:    d = DATA_REF_DIV;
            4'd2:    d = DATA_POWER;
            4'd3:    d = DATA_W'(job.div_word);
            4'd4:    d = DATA_VCO_TUNE;
            4'd5:    d = DATA_VCO_CLEAR;
            4'd6:    d = DATA_SD_CFG;
            4'd7:    d = DATA_LOCK_DET;
            4'd8:    d = DATA_CHARGE_PUMP;
            4'd9:    d = DATA_VCO_CAL;
            4'd10:   d = DATA_GPO;
            4'd11:   d = DATA_W'(job.int_part);
            4'd12:   d = job.frac;
            default: d = DATA_RESET;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/pll_frequency_programmer_core.sv
// ----------------------------------------------------------------------------
// pll_frequency_programmer_core - fractional-N PLL frequency programmer
// Turns a requested output frequency into the thirteen register writes that
// program the synthesizer: divider word, integer part and 24-bit fraction.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  word
//   --------  ---------  -------------------------  -------------------------
//   request   in         i_in_valid / o_in_ready    i_freq_khz
//   write     out        o_out_valid / i_out_ready  o_reg_address, o_reg_data,
//                                                   o_last
//
// Each request yields thirteen write words, one per cycle while the sink
// takes them. The arithmetic front works through a request in four divider
// steps of two quotient bits each, then six arithmetic and hand-off steps,
// so it runs ahead and parks finished jobs in a two-entry queue. A job
// reaches the sink through the front states, the queue and the registered
// output stage, where its first write word becomes valid.
// Synchronous active-low reset empties the queue and output stage; a stalled
// sink holds the current word and back-pressures the front through the queue.
//
`default_nettype none

module pll_frequency_programmer_core import pfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FREQ_W-1:0] i_freq_khz,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_reg_address,
    output logic [DATA_W-1:0] o_reg_data,
    output logic              o_last
);

    // front to queue
    logic w_push_valid, w_push_ready;
    t_job w_push_job;

    // queue to sequencer
    logic w_pop_valid, w_pop_ready;
    t_job w_pop_job;

    // clamp, divide and build divider word, integer and fraction
    pfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_freq_khz  (i_freq_khz),
        .o_job_valid (w_push_valid),
        .i_job_ready (w_push_ready),
        .o_job       (w_push_job)
    );

    // hold finished jobs so the front can start the next request
    pfp_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_job)
    );

    // emit the fixed write order; drop the job after its last word
    pfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_pop_valid),
        .o_job_ready   (w_pop_ready),
        .i_job         (w_pop_job),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

### rtl/pfp_front.sv
// ----------------------------------------------------------------------------
// pfp_front - request intake and frequency word arithmetic
// Clamps the request, divides 3000000 by it two quotient bits a cycle, then
// steps through the product, integer split and fraction terms.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_front import pfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FREQ_W-1:0] i_freq_khz,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output t_job              o_job
);

    t_front_state r_state, n_state;

    logic [FREQ_W-1:0] r_f;
    logic [FREQ_W-1:0] r_rem;
    logic [27:0]       r_dsr;
    logic [1:0]        r_step;
    logic [QUO_W-1:0]  r_q;
    logic [WORD_W-1:0] r_word;
    logic [FREQ_W-1:0] r_p;
    logic [INT_W-1:0]  r_int;
    logic [REM_W-1:0]  r_r;
    logic [FRAC_W-1:0] r_base;
    logic [10:0]       r_t5;
    logic [7:0]        r_t6;
    logic [3:0]        r_t7;
    logic [FRAC_W-1:0] r_frac;

    logic [FREQ_W-1:0] w_fclamp;
    logic [28:0]       w_r0, w_r1, w_r2, w_dhi, w_dlo;
    logic              w_bhi, w_blo;
    logic [DIV_W-1:0]  w_div;
    logic [WORD_W-1:0] w_word;
    logic [27:0]       w_pmul;
    logic [44:0]       w_imul;
    logic [FREQ_W-1:0] w_back;
    logic [32:0]       w_m5, w_m6;
    logic [17:0]       w_x3;
    logic [35:0]       w_m7;
    logic [FRAC_W-1:0] w_lin;

    // clamp to the supported range
    assign w_fclamp = (i_freq_khz > FREQ_MAX_KHZ) ? FREQ_MAX_KHZ :
                      (i_freq_khz < FREQ_MIN_KHZ) ? FREQ_MIN_KHZ : i_freq_khz;

    // two restoring steps per cycle
    assign w_r0  = 29'(r_rem);
    assign w_dhi = {r_dsr, 1'b0};
    assign w_dlo = {1'b0, r_dsr};
    assign w_bhi = (w_r0 >= w_dhi);
    assign w_r1  = w_bhi ? (w_r0 - w_dhi) : w_r0;
    assign w_blo = (w_r1 >= w_dlo);
    assign w_r2  = w_blo ? (w_r1 - w_dlo) : w_r1;

    // output divider and control word
    always_comb begin
        if (r_f > FREQ_DIV1_KHZ) begin
            w_div = DIV_ONE;
        end else if (r_q < QUO_LOW) begin
            w_div = DIV_MIN;
        end else if (r_q > QUO_W'(DIV_MAX)) begin
            w_div = DIV_MAX;
        end else begin
            w_div = {r_q[DIV_W-1:1], 1'b0};
        end
    end

    assign w_word = DIVWORD_BASE | (WORD_W'(w_div) << DIVWORD_SHIFT)
                  | ((w_div < 6'd3) ? DIVWORD_LOWDIV : '0);
    assign w_pmul = 28'(r_f) * 28'(w_div);

    // integer part and remainder in kHz
    assign w_imul = 45'(r_p) * 45'(INT_RECIP);
    assign w_back = FREQ_W'(r_int) * FREQ_W'(PFD_KHZ);

    // fraction terms that truncate
    assign w_m5  = 33'(r_r) * 33'(R25_RECIP);
    assign w_m6  = 33'(r_r) * 33'(R250_RECIP);
    assign w_x3  = 18'(r_r) + {1'b0, r_r, 1'b0};
    assign w_m7  = 36'(w_x3) * 36'(R7_RECIP);
    assign w_lin = FRAC_W'(r_r) * FRAC_W'(FRAC_LINEAR);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_in_valid) n_state = FS_DIV;
            end
            FS_DIV: begin
                if (r_step == 2'd0) n_state = FS_MUL;
            end
            FS_MUL:  n_state = FS_INT;
            FS_INT:  n_state = FS_REM;
            FS_REM:  n_state = FS_FRAC;
            FS_FRAC: n_state = FS_SUM;
            FS_SUM:  n_state = FS_PUSH;
            FS_PUSH: begin
                if (i_job_ready) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_job_valid = 1'b0;
        case (r_state)
            FS_IDLE: o_in_ready  = 1'b1;
            FS_PUSH: o_job_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_job_valid = 1'b0;
            end
        endcase
    end

    assign o_job.div_word = r_word;
    assign o_job.int_part = r_int;
    assign o_job.frac     = r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                r_f    <= w_fclamp;
                r_rem  <= FREQ_MAX_KHZ;
                r_dsr  <= {w_fclamp, 6'b0};
                r_step <= 2'd3;
                r_q    <= '0;
            end
            FS_DIV: begin
                r_rem  <= w_r2[FREQ_W-1:0];
                r_dsr  <= r_dsr >> 2;
                r_step <= r_step - 2'd1;
                r_q    <= {r_q[QUO_W-3:0], w_bhi, w_blo};
            end
            FS_MUL: begin
                r_word <= w_word;
                r_p    <= w_pmul[FREQ_W-1:0];
            end
            FS_INT: begin
                r_int <= w_imul[INT_SHIFT +: INT_W];
            end
            FS_REM: begin
                r_r <= REM_W'(r_p - w_back);
            end
            FS_FRAC: begin
                r_base <= w_lin;
                r_t5   <= w_m5[R25_SHIFT +: 11];
                r_t6   <= w_m6[R250_SHIFT +: 8];
                r_t7   <= w_m7[R7_SHIFT +: 4];
            end
            FS_SUM: begin
                r_frac <= r_base + FRAC_W'(r_r >> 1) + FRAC_W'(r_t5)
                        + FRAC_W'(r_t6) + FRAC_W'(r_t7);
            end
            default: begin
                r_frac <= r_frac;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/pfp_fifo.sv
// ----------------------------------------------------------------------------
// pfp_fifo - two-entry job queue
// Decouples the arithmetic front from the register write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_fifo import pfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_push_data;
    end

endmodule

`default_nettype wire

### rtl/pfp_back.sv
// ----------------------------------------------------------------------------
// pfp_back - register write sequencer
// Walks one job through the thirteen writes into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_back import pfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_reg_address,
    output logic [DATA_W-1:0] o_reg_data,
    output logic              o_last
);

    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic              w_load, w_at_last;

    // output stage is free when empty or being taken
    assign w_load      = !r_valid || i_out_ready;
    assign w_at_last   = (r_idx == LAST_IDX);
    assign o_job_ready = w_load && i_job_valid && w_at_last;

    assign o_out_valid   = r_valid;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= i_job_valid;
            if (i_job_valid) begin
                r_idx <= w_at_last ? '0 : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_job_valid) begin
            r_addr <= wr_addr(r_idx);
            r_data <= wr_data(r_idx, i_job);
            r_last <= w_at_last;
        end
    end

endmodule

`default_nettype wire

### rtl/pfp_checker.sv
// ----------------------------------------------------------------------------
// pfp_checker - port-level checks of the PLL frequency programmer
// Watches the write channel for sequence order and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module pfp_checker import pfp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [ADDR_W-1:0] o_reg_address,
    input logic [DATA_W-1:0] o_reg_data,
    input logic              o_last
);

    logic w_take;
    assign w_take = o_out_valid && i_out_ready;

    // integer write is directly followed by the closing fraction write
    a_int_then_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_reg_address == REG_INT)
        |=> (o_out_valid && o_last && o_reg_address == REG_FRAC))
        else $error("fraction write did not follow integer write");

    // a sequence opens with reset then reference divider, back to back
    a_reset_then_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_reg_address == REG_RESET)
        |=> (o_out_valid && !o_last && o_reg_address == REG_REF_DIV))
        else $error("reference divider write did not follow reset write");

    // two closing words never come back to back
    a_no_double_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_last) |=> !(o_out_valid && o_last))
        else $error("last flagged on consecutive words");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> (o_out_valid && $stable(o_reg_address) && $stable(o_reg_data)
             && $stable(o_last)))
        else $error("write word changed while stalled");

endmodule

bind pll_frequency_programmer_core pfp_checker u_pfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_reg_address (o_reg_address),
    .o_reg_data    (o_reg_data),
    .o_last        (o_last)
);

`default_nettype wire

### tb/tb_pll_frequency_programmer_core.sv
// ----------------------------------------------------------------------------
// tb_pll_frequency_programmer_core - self-checking bench for the PLL programmer
// Sends frequency requests through the request channel and checks every
// register write word against an in-bench calculation of divider, integer
// part and fraction, over phases with and without random idling on both sides.
// ----------------------------------------------------------------------------
module tb_pll_frequency_programmer_core;
    import pfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned WRITE_COUNT = 13;

    // one register write word as the sink should see it
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_write;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [FREQ_W-1:0] i_freq_khz;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [ADDR_W-1:0] o_reg_address;
    logic [DATA_W-1:0] o_reg_data;
    logic              o_last;

    logic [FREQ_W-1:0] request_queue[$];   // requests not yet offered
    t_write            pending_writes[$];  // writes predicted, not yet seen

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned request_count  = 0;
    int unsigned write_count    = 0;
    int unsigned cycle_count    = 0;
    logic        req_fire       = 1'b0;

    pll_frequency_programmer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_freq_khz    (i_freq_khz),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queue one predicted write word.
    function automatic void add_write(input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] data,
                                      input logic last);
        t_write w;
        w.addr = addr;
        w.data = data;
        w.last = last;
        pending_writes.push_back(w);
    endfunction

    // Work out the thirteen writes that one frequency request programs.
    function automatic void predict_writes(input logic [FREQ_W-1:0] req_khz);
        longint unsigned f;
        longint unsigned quo;
        longint unsigned div;
        longint unsigned vco_hz;
        longint unsigned whole;
        longint unsigned rem;
        longint unsigned frac;
        logic [WORD_W-1:0] div_word;
        longint unsigned digit[7];
        longint unsigned scale[7];
        digit = '{3, 3, 5, 5, 4, 4, 3};
        scale = '{10, 100, 1000, 10000, 100000, 1000000, 10000000};

        // saturate to the supported band, so zero never reaches the divide
        f = req_khz;
        if (f > 3000000) f = 3000000;
        if (f < 25000) f = 25000;

        // output divider: bypass at the top octave, else even and capped
        if (f > 1500000) begin
            div = 1;
        end else begin
            quo = 3000000 / f;
            if (quo < 3) div = 2;
            else if (quo > 62) div = 62;
            else div = quo & ~64'd1;
        end

        div_word = 16'h6010 | WORD_W'(div << 7);
        if (div < 3) div_word = div_word | 16'h8000;

        // split the VCO rate at 50 MHz; fraction is the plain truncated sum
        vco_hz = f * div * 1000;
        whole  = vco_hz / 50000000;
        rem    = vco_hz % 50000000;
        frac   = 0;
        for (int k = 0; k < 7; k++) frac += (digit[k] * rem) / scale[k];

        add_write(REG_RESET,       DATA_RESET,                1'b0);
        add_write(REG_REF_DIV,     DATA_REF_DIV,              1'b0);
        add_write(REG_POWER,       DATA_POWER,                1'b0);
        add_write(REG_VCO_SPI,     DATA_W'(div_word),         1'b0);
        add_write(REG_VCO_SPI,     DATA_VCO_TUNE,             1'b0);
        add_write(REG_VCO_SPI,     DATA_VCO_CLEAR,            1'b0);
        add_write(REG_SD_CFG,      DATA_SD_CFG,               1'b0);
        add_write(REG_LOCK_DET,    DATA_LOCK_DET,             1'b0);
        add_write(REG_CHARGE_PUMP, DATA_CHARGE_PUMP,          1'b0);
        add_write(REG_VCO_CAL,     DATA_VCO_CAL,              1'b0);
        add_write(REG_GPO,         DATA_GPO,                  1'b0);
        add_write(REG_INT,         DATA_W'(whole & 64'hFF),   1'b0);
        add_write(REG_FRAC,        DATA_W'(frac & 64'hFFFFFF), 1'b1);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Pick a random request: mostly in band, weighted toward low frequencies
    // where the divider steps through many values, plus raw and edge values.
    function automatic logic [FREQ_W-1:0] random_freq();
        logic [FREQ_W-1:0] edge_pt[6];
        int unsigned sel;
        edge_pt = '{22'd25000, 22'd48387, 22'd750000, 22'd1000000,
                    22'd1500000, 22'd3000000};
        sel = $urandom_range(9);
        if (sel < 2) return FREQ_W'($urandom);
        if (sel == 2) return edge_pt[$urandom_range(5)] + FREQ_W'($urandom_range(4)) - 22'd2;
        if (sel < 6) return FREQ_W'($urandom_range(200000, 25000));
        return FREQ_W'($urandom_range(3000000, 25000));
    endfunction

    // Hold until every request is taken and every predicted write has come.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (request_queue.size() != 0 || i_in_valid || pending_writes.size() != 0);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned n_items, input bit mid_pause);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int unsigned n = 0; n < n_items; n++) begin
            request_queue.push_back(random_freq());
            // stop feeding halfway and let the write queue run dry
            if (mid_pause && n == n_items / 2) wait_drained();
        end
        wait_drained();
    endtask

    // Request driver: change inputs on the falling edge only. Advance to the
    // next request once the current word was taken at the last rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_fire) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_freq_khz <= request_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: sample both handshakes on the rising edge. Predict on every
    // accepted request, then check an accepted write against the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_write want;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                predict_writes(i_freq_khz);
                request_count++;
            end
            if (o_out_valid && i_out_ready) begin
                write_count++;
                if (pending_writes.size() == 0) begin
                    report_mismatch("unexpected write address", o_reg_address, 0);
                end else begin
                    want = pending_writes.pop_front();
                    if (o_reg_address !== want.addr)
                        report_mismatch("reg_address", o_reg_address, want.addr);
                    if (o_reg_data !== want.data)
                        report_mismatch("reg_data", o_reg_data, want.data);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
        end
    end

    // Watchdog: drop the run once the cycle count reaches its limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [FREQ_W-1:0] directed[25];
        directed = '{22'd0, 22'd1, 22'd24999, 22'd25000, 22'd25001,
                     22'd47000, 22'd48386, 22'd48387, 22'd48388, 22'd50000,
                     22'd60000, 22'd750000, 22'd999999, 22'd1000000, 22'd1000001,
                     22'd1499999, 22'd1500000, 22'd1500001, 22'd2999999, 22'd3000000,
                     22'd3000001, 22'h3FFFFF, 22'h2AAAAA, 22'h155555, 22'd1234567};

        // drive every input to a known value before the first edge
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_freq_khz = '0;
        i_out_ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners with no idling: band edges, divider steps, raw extremes
        foreach (directed[k]) request_queue.push_back(directed[k]);
        wait_drained();

        run_phase(0, 0, 60, 1'b0);
        run_phase(78, 0, 60, 1'b0);
        run_phase(0, 78, 60, 1'b0);
        run_phase(31, 31, 70, 1'b1);

        // hold for stray writes past the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d frequency requests and %0d register write words",
                 request_count, write_count);
        $display("over four idle/stall mixes, with a full drain between each.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pfp_pkg.sv
rtl/pfp_front.sv
rtl/pfp_fifo.sv
rtl/pfp_back.sv
rtl/pll_frequency_programmer_core.sv
rtl/pfp_checker.sv
tb/tb_pll_frequency_programmer_core.sv
